@@ src/fat_pkg.sv @@
// Shared types and constants for the flow accounting table.
// Used by fat_cell and flow_accounting_table; depends on nothing else.
package fat_pkg;

	localparam int unsigned FAT_DEPTH = 1024;
	localparam int unsigned CAP_W     = 11;
	localparam int unsigned ENTRY_W   = 10;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// One packet header as it travels down the row of cells, together with
	// the result it picks up at the cell that resolves it.
	typedef struct packed {
		logic               valid;
		logic               done;
		logic [31:0]        src_addr;
		logic [31:0]        dst_addr;
		logic [15:0]        sport;
		logic [15:0]        dport;
		logic [15:0]        len;
		logic [1:0]         status;
		logic [ENTRY_W-1:0] entry;
		logic [63:0]        bytes;
		logic [63:0]        pkts;
	} fat_word_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic             advance;
		logic [CAP_W-1:0] capacity;
	} fat_ctl_t;

endpackage

@@ src/fat_cell.sv @@
// One slot of the flow table: key, byte and packet counters, and the stage
// register that hands the travelling word on. Depends on fat_pkg.
module fat_cell import fat_pkg::*; #(
	parameter int unsigned CNT_W = 11,
	parameter int unsigned IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fat_ctl_t         ctl,
	input  logic [CNT_W-1:0] used,
	input  fat_word_t        word_i,
	output fat_word_t        word_o,
	output logic             ins
);

	localparam int unsigned CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CNT_W-1:0]   MY_POS   = CNT_W'(IDX);
	localparam logic [CW-1:0]      MY_POS_W = CW'(IDX);
	localparam logic [ENTRY_W-1:0] MY_ENTRY = ENTRY_W'(IDX);

	logic [31:0] key_src_addr_q;
	logic [31:0] key_dst_addr_q;
	logic [15:0] key_sport_q;
	logic [15:0] key_dport_q;
	logic [63:0] bytes_q;
	logic [63:0] pkts_q;
	logic        valid_q;
	fat_word_t   word_q;

	logic        open;
	logic        occupied;
	logic        key_eq;
	logic        hit;
	logic        tail;
	logic        room;
	logic [63:0] sum_bytes;
	logic [63:0] sum_pkts;
	fat_word_t   nxt;

	assign open      = word_i.valid && !word_i.done;
	assign occupied  = MY_POS < used;
	assign key_eq    = (key_src_addr_q == word_i.src_addr) && (key_dst_addr_q == word_i.dst_addr)
		&& (key_sport_q == word_i.sport) && (key_dport_q == word_i.dport);
	assign hit       = open && occupied && key_eq;
	// The first free slot is where a missing flow gets appended.
	assign tail      = open && (MY_POS == used);
	assign room      = MY_POS_W < CW'(ctl.capacity);
	assign sum_bytes = bytes_q + 64'(word_i.len);
	assign sum_pkts  = pkts_q + 64'd1;
	assign ins       = ctl.advance && tail && room;

	always_comb begin
		nxt = word_i;
		if (hit) begin
			nxt.done   = 1'b1;
			nxt.status = ST_UPDATED;
			nxt.entry  = MY_ENTRY;
			nxt.bytes  = sum_bytes;
			nxt.pkts   = sum_pkts;
		end else if (tail) begin
			nxt.done = 1'b1;
			if (room) begin
				nxt.status = ST_INSERTED;
				nxt.entry  = MY_ENTRY;
				nxt.bytes  = 64'(word_i.len);
				nxt.pkts   = 64'd1;
			end else begin
				nxt.status = ST_FULL;
				nxt.entry  = '0;
				nxt.bytes  = '0;
				nxt.pkts   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.advance) begin
			valid_q <= word_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			word_q <= nxt;
		end
		if (ctl.advance && hit) begin
			bytes_q <= sum_bytes;
			pkts_q  <= sum_pkts;
		end else if (ins) begin
			key_src_addr_q <= word_i.src_addr;
			key_dst_addr_q <= word_i.dst_addr;
			key_sport_q    <= word_i.sport;
			key_dport_q    <= word_i.dport;
			bytes_q        <= 64'(word_i.len);
			pkts_q         <= 64'd1;
		end
	end

	always_comb begin
		word_o       = word_q;
		word_o.valid = valid_q;
	end

endmodule

@@ src/flow_accounting_table.sv @@
// Top level of the exact-match flow table with per-flow byte and packet counters.
// Instantiates a row of fat_cell slots; depends on fat_pkg.
//
// Usage: each input word is one packet header (addresses, ports, length) on
// in_valid/in_stall. A word is taken at a rising edge with in_valid high and
// in_stall low. Each word yields exactly one result word on out_valid/out_stall:
// the flow was updated, a new flow was inserted, or the table was full and the
// packet dropped (index and counters zero).
// The header walks down a row of TABLE_DEPTH cells, one cell per cycle while the
// row is not frozen. Each cell compares the header with its stored key and, on a
// match, bumps its counters; the first free cell appends the flow if capacity
// allows. Words that follow directly behind see every change made by the word
// ahead of them, so a new word is taken every cycle unless the row is frozen, and
// its result leaves through the last cell's stage register. When the receiver
// stalls a waiting result, the whole row freezes and in_stall rises until the
// result is taken. Reset empties the table (flow count zero) and sets capacity
// to 1024. Capacity is written through capacity_wr/capacity_data; the user must
// do so only while the block is idle, and the block itself does not enforce it.
module flow_accounting_table import fat_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = FAT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               capacity_wr,
	input  logic [CAP_W-1:0]   capacity_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        src_addr,
	input  logic [31:0]        dst_addr,
	input  logic [15:0]        sport,
	input  logic [15:0]        dport,
	input  logic [15:0]        pkt_len,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [ENTRY_W-1:0] entry_index,
	output logic [63:0]        byte_total,
	output logic [63:0]        packet_total
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       used_q;
	fat_ctl_t               ctl;
	fat_word_t              chain [0:TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] ins_vec;

	// The last cell's stage register doubles as the output register.
	assign ctl.advance  = !(chain[TABLE_DEPTH].valid && out_stall);
	assign ctl.capacity = cap_q;
	assign in_stall     = !ctl.advance;

	// A header enters already marked as a drop; a cell that resolves it
	// overwrites the result fields. Reaching the end unresolved means the
	// table was full.
	always_comb begin
		chain[0].valid    = in_valid;
		chain[0].done     = 1'b0;
		chain[0].src_addr = src_addr;
		chain[0].dst_addr = dst_addr;
		chain[0].sport    = sport;
		chain[0].dport    = dport;
		chain[0].len      = pkt_len;
		chain[0].status   = ST_FULL;
		chain[0].entry    = '0;
		chain[0].bytes    = '0;
		chain[0].pkts     = '0;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		fat_cell #(
			.CNT_W (CNT_W),
			.IDX   (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.used   (used_q),
			.word_i (chain[g]),
			.word_o (chain[g+1]),
			.ins    (ins_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			used_q <= '0;
		end else begin
			if (capacity_wr) begin
				cap_q <= capacity_data;
			end
			if (|ins_vec) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	assign out_valid    = chain[TABLE_DEPTH].valid;
	assign status       = chain[TABLE_DEPTH].status;
	assign entry_index  = chain[TABLE_DEPTH].entry;
	assign byte_total   = chain[TABLE_DEPTH].bytes;
	assign packet_total = chain[TABLE_DEPTH].pkts;

	// Only the cell at the free boundary may append, so at most one per cycle.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(ins_vec))
		else $error("more than one cell appended a flow in one cycle");

	// The flow count never passes the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= CNT_W'(TABLE_DEPTH))
		else $error("flow count exceeds the table depth");

	// The flow count only ever steps up by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("flow count changed by other than one");

	// An append only happens while the table is below capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(|ins_vec) |-> (CW'(used_q) < CW'(cap_q)))
		else $error("flow appended at or above capacity");

endmodule
